// ===== hdl/dtmm_pkg.sv =====
// Shared constants for the direct-address table with lowest/highest key tracking.
package dtmm_pkg;

    localparam int DEPTH_DEF      = 32;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int KIND_W  = 2;
    localparam int KEY_W   = 32;
    localparam int VALUE_W = 32;

    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_GET    = 2'd2;

endpackage

// ===== hdl/dtmm_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module dtmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== hdl/dtmm_minmax.sv =====
// Priority encoders giving the lowest and highest set bit of the occupancy map.
module dtmm_minmax #(
    parameter int DEPTH = 32
) (
    input  logic [DEPTH-1:0]         occupied,
    output logic                     any_set,
    output logic [$clog2(DEPTH)-1:0] low_idx,
    output logic [$clog2(DEPTH)-1:0] high_idx
);

    localparam int IDX_W = $clog2(DEPTH);

    assign any_set = |occupied;

    // scan from the top so the lowest set bit wins
    always_comb begin
        low_idx = '0;
        for (int i = DEPTH - 1; i >= 0; i--) begin
            if (occupied[i]) begin
                low_idx = IDX_W'(i);
            end
        end
    end

    // scan from the bottom so the highest set bit wins
    always_comb begin
        high_idx = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (occupied[i]) begin
                high_idx = IDX_W'(i);
            end
        end
    end

endmodule

// ===== hdl/direct_table_with_min_max.sv =====
// Top level of the direct-address table with lowest/highest occupied key tracking.
//
// A table of DEPTH slots addressed by key minus the configured base (cfg_wr_data,
// written by the user with cfg_wr_en while the block is idle; not enforced). Each
// request transaction is insert (kind 0, keeps the first value stored), remove
// (kind 1) or get (kind 2); every request yields exactly one result transaction
// carrying the hit flag, the stored word on a successful get, a key-out-of-range
// flag, and the lowest and highest occupied keys after the request (zero, with
// table_empty set, when no slot is occupied). Kind 3 changes nothing. The block
// takes one transaction per clock unless the result stalls. Acceptance loads the
// request register and launches the data RAM read (its registered read port is why
// the request is registered first); when the request advances, the occupancy
// bitmap is updated, the min/max priority encoders run and the result register is
// loaded. A stalled result holds the request register, and s_ready drops until it
// drains. No clearing pass is needed after reset: occupancy lives in flip-flops.
module direct_table_with_min_max #(
    parameter int DEPTH      = dtmm_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = dtmm_pkg::DATA_WIDTH_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    // configuration
    input  logic                                cfg_wr_en,
    input  logic signed [dtmm_pkg::KEY_W-1:0]   cfg_wr_data,
    // request channel
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic        [dtmm_pkg::KIND_W-1:0]  s_kind,
    input  logic signed [dtmm_pkg::KEY_W-1:0]   s_key,
    input  logic        [dtmm_pkg::VALUE_W-1:0] s_value,
    // result channel
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic        [dtmm_pkg::VALUE_W-1:0] m_read_value,
    output logic                                m_hit,
    output logic                                m_key_error,
    output logic                                m_table_empty,
    output logic signed [dtmm_pkg::KEY_W-1:0]   m_lowest_key,
    output logic signed [dtmm_pkg::KEY_W-1:0]   m_highest_key
);

    import dtmm_pkg::*;

    localparam int IDX_W = $clog2(DEPTH);

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic signed [KEY_W-1:0] key_base_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_base_reg <= '0;
        end else if (cfg_wr_en) begin
            key_base_reg <= cfg_wr_data;
        end
    end

    // ------------------------------------------------------------------
    // Acceptance: work out the slot offset at full width, no wrap
    // ------------------------------------------------------------------
    logic                    s_accept;
    logic signed [KEY_W:0]   offset;
    logic                    in_range;
    logic [IDX_W-1:0]        s_idx;
    logic [DATA_WIDTH-1:0]   value_w;

    assign s_accept = s_valid && s_ready;
    assign offset   = $signed({s_key[KEY_W-1], s_key})
                    - $signed({key_base_reg[KEY_W-1], key_base_reg});
    assign in_range = !offset[KEY_W] && (offset[KEY_W:0] < (KEY_W+1)'(DEPTH));
    assign s_idx    = offset[IDX_W-1:0];

    // fit the input word to the stored width
    generate
        if (DATA_WIDTH > VALUE_W) begin : g_val_wide
            assign value_w = {{(DATA_WIDTH-VALUE_W){1'b0}}, s_value};
        end else if (DATA_WIDTH == VALUE_W) begin : g_val_same
            assign value_w = s_value;
        end else begin : g_val_narrow
            assign value_w = s_value[DATA_WIDTH-1:0];
        end
    endgenerate

    // ------------------------------------------------------------------
    // Stage 1: request register, RAM read data arrives alongside
    // ------------------------------------------------------------------
    logic                  s1_valid_reg;
    logic [KIND_W-1:0]     s1_kind_reg;
    logic [IDX_W-1:0]      s1_idx_reg;
    logic                  s1_kerr_reg;
    logic [DATA_WIDTH-1:0] s1_value_reg;
    logic                  fwd_valid_reg;
    logic [DATA_WIDTH-1:0] fwd_data_reg;
    logic                  fwd_valid_next;
    logic                  s1_advance;
    logic                  m_valid_reg;

    logic [DEPTH-1:0]      slot_valid_reg;
    logic [DEPTH-1:0]      slot_valid_next;
    logic [DEPTH-1:0]      slot_after;

    logic [DATA_WIDTH-1:0] ram_rdata;
    logic [DATA_WIDTH-1:0] slot_word;
    logic                  slot_occ;
    logic                  do_insert;
    logic                  do_remove;
    logic                  get_hit;
    logic                  hit;

    assign s1_advance = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready    = !s1_valid_reg || s1_advance;

    assign slot_occ = slot_valid_reg[s1_idx_reg];

    // decode the request against the current occupancy
    always_comb begin
        do_insert = 1'b0;
        do_remove = 1'b0;
        get_hit   = 1'b0;
        hit       = 1'b0;
        if (!s1_kerr_reg) begin
            case (s1_kind_reg)
                KIND_INSERT: begin
                    do_insert = !slot_occ;
                    hit       = !slot_occ;
                end
                KIND_REMOVE: begin
                    do_remove = 1'b1;
                    hit       = slot_occ;
                end
                KIND_GET: begin
                    get_hit = slot_occ;
                    hit     = slot_occ;
                end
                default: begin
                    hit = 1'b0;
                end
            endcase
        end
    end

    // occupancy after this request; commit it only when the request advances
    always_comb begin
        slot_after = slot_valid_reg;
        if (do_insert) begin
            slot_after[s1_idx_reg] = 1'b1;
        end
        if (do_remove) begin
            slot_after[s1_idx_reg] = 1'b0;
        end
        slot_valid_next = s1_advance ? slot_after : slot_valid_reg;
    end

    // a write landing on the same slot as the read issued at that edge is forwarded
    assign fwd_valid_next = s1_advance && do_insert && (s1_idx_reg == s_idx);
    assign slot_word      = fwd_valid_reg ? fwd_data_reg : ram_rdata;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_valid_reg <= '0;
            s1_valid_reg   <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end else begin
            slot_valid_reg <= slot_valid_next;
            if (s_accept) begin
                s1_valid_reg  <= 1'b1;
                fwd_valid_reg <= fwd_valid_next;
            end else if (s1_advance) begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_kind_reg  <= s_kind;
            s1_idx_reg   <= s_idx;
            s1_kerr_reg  <= !in_range;
            s1_value_reg <= value_w;
            fwd_data_reg <= s1_value_reg;
        end
    end

    dtmm_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_data_ram (
        .aclk    (aclk),
        .wr_en   (s1_advance && do_insert),
        .wr_addr (s1_idx_reg),
        .wr_data (s1_value_reg),
        .rd_en   (s_accept),
        .rd_addr (s_idx),
        .rd_data (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Lowest and highest occupied slot after the request
    // ------------------------------------------------------------------
    logic             any_occ;
    logic [IDX_W-1:0] low_idx;
    logic [IDX_W-1:0] high_idx;

    dtmm_minmax #(
        .DEPTH (DEPTH)
    ) u_minmax (
        .occupied (slot_after),
        .any_set  (any_occ),
        .low_idx  (low_idx),
        .high_idx (high_idx)
    );

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [VALUE_W-1:0]      read_value_next;
    logic [DATA_WIDTH-1:0]   read_word;
    logic [VALUE_W-1:0]      read_value_reg;
    logic                    hit_reg;
    logic                    kerr_reg;
    logic                    empty_reg;
    logic signed [KEY_W-1:0] low_key_next;
    logic signed [KEY_W-1:0] high_key_next;
    logic signed [KEY_W-1:0] low_key_reg;
    logic signed [KEY_W-1:0] high_key_reg;

    assign read_word = get_hit ? slot_word : '0;

    // fit the stored word to the result width
    generate
        if (DATA_WIDTH > VALUE_W) begin : g_rd_wide
            assign read_value_next = read_word[VALUE_W-1:0];
        end else if (DATA_WIDTH == VALUE_W) begin : g_rd_same
            assign read_value_next = read_word;
        end else begin : g_rd_narrow
            assign read_value_next = {{(VALUE_W-DATA_WIDTH){1'b0}}, read_word};
        end
    endgenerate

    // keys wrap to 32 bits when the base sits near the top of the range
    assign low_key_next  = any_occ ? key_base_reg + KEY_W'(low_idx)  : '0;
    assign high_key_next = any_occ ? key_base_reg + KEY_W'(high_idx) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (s1_advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_advance) begin
            read_value_reg <= read_value_next;
            hit_reg        <= hit;
            kerr_reg       <= s1_kerr_reg;
            empty_reg      <= !any_occ;
            low_key_reg    <= low_key_next;
            high_key_reg   <= high_key_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_read_value  = read_value_reg;
    assign m_hit         = hit_reg;
    assign m_key_error   = kerr_reg;
    assign m_table_empty = empty_reg;
    assign m_lowest_key  = low_key_reg;
    assign m_highest_key = high_key_reg;

endmodule
